// ===== hdl/nsr_pkg.sv =====
// Shared constants and types for the Newton square root block.
// No dependencies; used by newton_square_root and nsr_checker.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

   localparam int RADICAND_BITS = 31;
   localparam int ROOT_BITS     = 40;
   localparam int FRAC_BITS     = 24;

   // estimate and quotient never reach 2^(RADICAND_BITS + FRAC_BITS)
   localparam int Y_BITS        = RADICAND_BITS + FRAC_BITS + 1;
   localparam int DIV_STEPS     = RADICAND_BITS + 2 * FRAC_BITS;
   localparam int STEP_BITS     = $clog2(DIV_STEPS);

   // convergence test: |dy| * STOP_FACTOR < y
   localparam int STOP_BITS     = 17;
   localparam logic [STOP_BITS-1:0] STOP_FACTOR = STOP_BITS'(100000);
   localparam int PROD_BITS     = Y_BITS + STOP_BITS;

   localparam int ROUND_LIMIT   = 64;
   localparam int ROUND_BITS    = $clog2(ROUND_LIMIT);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_UPD  = 7'b0000100,
      ST_DIF  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_CHK  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/newton_square_root.sv =====
// Newton-Raphson square root of a 31-bit unsigned integer, result in fixed point.
// Depends on nsr_pkg for widths, constants and the sequencer state type.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel req_valid/req_ready carries one item: req_radicand.
//   Result channel rsp_valid/rsp_ready returns one item per input: rsp_root,
//   unsigned with 24 fraction bits, saturated to all ones if it overflows.
//   The block works on one item at a time. req_ready is high only while the
//   sequencer is idle; it may take a new item while the previous result still
//   sits in the output register waiting for rsp_ready.
// Sequence
//   Zero radicand: goes straight to the final state without any Newton round.
//   Otherwise each Newton round runs 79 steps of restoring division (one
//   quotient bit per cycle through a single subtractor), the estimate update,
//   the |dy| step, a 17-step shift-add multiply of |dy| by 100000, and the
//   stop compare. There are R rounds, at most 64; a new item is taken only
//   after the result has moved to the output register.
// Reset
//   Synchronous, active high: sequencer returns to idle, no result is valid.
// Stall
//   A finished result holds in the output register until rsp_ready; the
//   sequencer waits in its final state if the register is still occupied.

module newton_square_root (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [nsr_pkg::RADICAND_BITS-1:0]   req_radicand,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [nsr_pkg::ROOT_BITS-1:0]       rsp_root
);

   localparam int YB = nsr_pkg::Y_BITS;
   localparam int PB = nsr_pkg::PROD_BITS;

   nsr_pkg::state_type                   state_ff, state_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [nsr_pkg::ROOT_BITS-1:0]        root_ff, root_in;
   logic [nsr_pkg::RADICAND_BITS-1:0]    x_ff, x_in;      // radicand
   logic [nsr_pkg::RADICAND_BITS-1:0]    xs_ff, xs_in;    // dividend bits, msb first
   logic [YB-1:0]                        y_ff, y_in;      // current estimate
   logic [YB-1:0]                        old_ff, old_in;  // previous estimate
   logic [YB-1:0]                        rem_ff, rem_in;
   logic [YB-1:0]                        quo_ff, quo_in;
   logic [YB-1:0]                        dy_ff, dy_in;
   logic [PB-1:0]                        acc_ff, acc_in;
   logic [nsr_pkg::STOP_BITS-1:0]        fac_ff, fac_in;
   logic [nsr_pkg::STEP_BITS-1:0]        step_ff, step_in;
   logic [nsr_pkg::ROUND_BITS-1:0]       round_ff, round_in;

   logic [YB:0]                          rem_sh;
   logic [YB+1:0]                        rem_diff;
   logic [YB:0]                          y_sum;
   logic [YB:0]                          y_delta;
   logic [PB-1:0]                        acc_next;
   logic                                 stop;

   assign req_ready = (state_ff == nsr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = root_ff;

   // datapath pieces
   assign rem_sh   = {rem_ff, xs_ff[nsr_pkg::RADICAND_BITS-1]};
   assign rem_diff = {1'b0, rem_sh} - {2'b00, y_ff};
   assign y_sum    = {1'b0, y_ff} + {1'b0, quo_ff};
   assign y_delta  = {1'b0, y_ff} - {1'b0, old_ff};
   assign acc_next = {acc_ff[PB-2:0], 1'b0}
                   + (fac_ff[nsr_pkg::STOP_BITS-1] ? {{nsr_pkg::STOP_BITS{1'b0}}, dy_ff}
                                                    : {PB{1'b0}});
   assign stop     = (y_ff == '0)
                   || (acc_ff < {{nsr_pkg::STOP_BITS{1'b0}}, y_ff})
                   || (round_ff == nsr_pkg::ROUND_BITS'(nsr_pkg::ROUND_LIMIT - 1));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      root_in      = root_ff;
      x_in         = x_ff;
      xs_in        = xs_ff;
      y_in         = y_ff;
      old_in       = old_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      fac_in       = fac_ff;
      step_in      = step_ff;
      round_in     = round_ff;

      case (state_ff)
         nsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_radicand;
               xs_in    = req_radicand;
               round_in = '0;
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               if (req_radicand == '0) begin
                  y_in     = '0;
                  state_in = nsr_pkg::ST_DONE;
               end else begin
                  y_in     = YB'(1) << nsr_pkg::FRAC_BITS;
                  state_in = nsr_pkg::ST_DIV;
               end
            end
         end
         nsr_pkg::ST_DIV: begin
            // one restoring-division step: quotient bit from the borrow
            xs_in  = {xs_ff[nsr_pkg::RADICAND_BITS-2:0], 1'b0};
            if (rem_diff[YB+1]) begin
               rem_in = rem_sh[YB-1:0];
               quo_in = {quo_ff[YB-2:0], 1'b0};
            end else begin
               rem_in = rem_diff[YB-1:0];
               quo_in = {quo_ff[YB-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == nsr_pkg::STEP_BITS'(nsr_pkg::DIV_STEPS - 1)) begin
               state_in = nsr_pkg::ST_UPD;
            end
         end
         nsr_pkg::ST_UPD: begin
            old_in   = y_ff;
            y_in     = y_sum[YB:1];
            state_in = nsr_pkg::ST_DIF;
         end
         nsr_pkg::ST_DIF: begin
            dy_in    = y_delta[YB] ? (old_ff - y_ff) : y_delta[YB-1:0];
            acc_in   = '0;
            fac_in   = nsr_pkg::STOP_FACTOR;
            step_in  = '0;
            state_in = nsr_pkg::ST_MUL;
         end
         nsr_pkg::ST_MUL: begin
            // |dy| * STOP_FACTOR, one factor bit per cycle, msb first
            acc_in  = acc_next;
            fac_in  = {fac_ff[nsr_pkg::STOP_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == nsr_pkg::STEP_BITS'(nsr_pkg::STOP_BITS - 1)) begin
               state_in = nsr_pkg::ST_CHK;
            end
         end
         nsr_pkg::ST_CHK: begin
            if (stop) begin
               state_in = nsr_pkg::ST_DONE;
            end else begin
               round_in = round_ff + 1'b1;
               xs_in    = x_ff;
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = nsr_pkg::ST_DIV;
            end
         end
         nsr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               root_in      = (|y_ff[YB-1:nsr_pkg::ROOT_BITS]) ? {nsr_pkg::ROOT_BITS{1'b1}}
                                                               : y_ff[nsr_pkg::ROOT_BITS-1:0];
               state_in     = nsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nsr_pkg::ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      root_ff  <= root_in;
      x_ff     <= x_in;
      xs_ff    <= xs_in;
      y_ff     <= y_in;
      old_ff   <= old_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dy_ff    <= dy_in;
      acc_ff   <= acc_in;
      fac_ff   <= fac_in;
      step_ff  <= step_in;
      round_ff <= round_in;
   end

endmodule

`default_nettype wire

// ===== hdl/nsr_checker.sv =====
// Port-level assertions for newton_square_root, attached by bind.
// Depends on nsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module nsr_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire [nsr_pkg::RADICAND_BITS-1:0]   req_radicand,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [nsr_pkg::ROOT_BITS-1:0]       rsp_root
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root))
      else $error("result item changed while stalled");

   // no result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: busy after every accepted item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("took a second item while busy");

   // a zero radicand never yields a result in the cycle after it is taken
   a_zero_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_radicand == '0) && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_radicand (req_radicand),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_root     (rsp_root)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for newton_square_root: random and corner radicands go in, roots are checked.
// Depends on nsr_pkg and newton_square_root from the RTL; it has its own Newton root predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int RADICAND_BITS = nsr_pkg::RADICAND_BITS;
   localparam int ROOT_BITS     = nsr_pkg::ROOT_BITS;
   localparam int FRAC_BITS     = nsr_pkg::FRAC_BITS;

   // predictor constants: stop when |dy| * 100000 < y, give up after 64 rounds
   localparam longint unsigned CLOSE_ENOUGH_DIV = 100000;
   localparam int              MAX_ROUNDS       = 64;
   // the longest compute runs all 64 Newton rounds; the stalls on top of that are short
   localparam int              HANG_LIMIT       = 40000;
   localparam int              RESET_CYCLES     = 9;
   localparam int              DIRECTED_COUNT   = 22;
   localparam int              RANDOM_COUNT     = 558;
   localparam int              TAIL_CYCLES      = 200;

   // flow-control phases: slow receiver, then slow sender, then both at full rate
   typedef enum logic [1:0] {
      PH_SLOW_RECEIVER,
      PH_SLOW_SENDER,
      PH_FULL_RATE
   } flow_phase_type;

   typedef struct {
      logic [RADICAND_BITS-1:0] radicand;
      flow_phase_type           phase;
      bit                       drain_first;   // hold off until all roots are back
   } radicand_item_type;

   typedef struct {
      logic [RADICAND_BITS-1:0] radicand;
      logic [ROOT_BITS-1:0]     root;
   } root_item_type;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   logic [RADICAND_BITS-1:0] req_radicand = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   logic [ROOT_BITS-1:0]     rsp_root;

   radicand_item_type pending_radicands[$];
   root_item_type     awaited_roots[$];
   flow_phase_type    run_phase      = PH_SLOW_RECEIVER;
   int unsigned       issued_count   = 0;
   int unsigned       returned_count = 0;
   int unsigned       error_count    = 0;

   newton_square_root uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_radicand (req_radicand),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_root     (rsp_root)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Newton iteration y = (y + x/y) / 2 in fixed point, starting at 1.0.
   // The quotient is floor((x << 2*FRAC_BITS) / y), so it keeps FRAC_BITS fraction bits.
   function automatic logic [ROOT_BITS-1:0] newton_root(input logic [RADICAND_BITS-1:0] x);
      logic [127:0]    scaled;
      longint unsigned estimate;
      longint unsigned previous;
      longint unsigned quotient;
      longint unsigned change;
      bit              settled;
      if (x == 0)
         return '0;   // zero radicand skips the iteration entirely
      estimate = 64'd1 << FRAC_BITS;
      settled  = 1'b0;
      scaled   = 128'(x) << (2 * FRAC_BITS);
      for (int round = 0; round < MAX_ROUNDS && !settled; round++) begin
         previous = estimate;
         quotient = 64'(scaled / 128'(estimate));
         estimate = (estimate + quotient) >> 1;
         if (estimate == 0) begin
            settled = 1'b1;
         end else begin
            change = (estimate > previous) ? estimate - previous : previous - estimate;
            // integer form of change * 100000 < estimate
            if (change <= (estimate - 1) / CLOSE_ENOUGH_DIV)
               settled = 1'b1;
         end
      end
      // a round-limit exit just keeps the estimate it ended with
      if (estimate > {ROOT_BITS{1'b1}})
         return {ROOT_BITS{1'b1}};
      return estimate[ROOT_BITS-1:0];
   endfunction

   function automatic int sender_idle_pct(input flow_phase_type phase);
      case (phase)
         PH_SLOW_RECEIVER: return 29;
         PH_SLOW_SENDER:   return 82;
         default:          return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(input flow_phase_type phase);
      case (phase)
         PH_SLOW_RECEIVER: return 82;
         PH_SLOW_SENDER:   return 29;
         default:          return 0;
      endcase
   endfunction

   // Mix of magnitudes: full range costs ~20 rounds, small values only a few,
   // so the run stays short while still hitting the top bits often.
   function automatic logic [RADICAND_BITS-1:0] random_radicand();
      int unsigned base;
      case ($urandom_range(0, 9))
         0, 1, 2: return RADICAND_BITS'($urandom);
         3, 4:    return RADICAND_BITS'($urandom_range(1, 1000));
         5, 6:    return RADICAND_BITS'($urandom) >> $urandom_range(0, RADICAND_BITS - 1);
         7, 8: begin
            // exact squares and their neighbors
            base = $urandom_range(1, 46340);
            return RADICAND_BITS'(base * base + $urandom_range(0, 2) - 1);
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return RADICAND_BITS'(1);
               2:       return {RADICAND_BITS{1'b1}};
               default: return {RADICAND_BITS{1'b1}} - RADICAND_BITS'($urandom_range(1, 15));
            endcase
         end
      endcase
   endfunction

   function automatic void queue_radicand(input logic [RADICAND_BITS-1:0] value,
                                          input flow_phase_type phase, input bit drain_first);
      radicand_item_type item;
      item.radicand    = value;
      item.phase       = phase;
      item.drain_first = drain_first;
      pending_radicands.push_back(item);
   endfunction

   // Driver: valid stays up with a stable radicand until accepted. The expected
   // root is computed at acceptance. Counters are compared at their pre-edge
   // values so the drain hold-off does not depend on block ordering.
   always @(posedge clock) begin
      radicand_item_type next_item;
      root_item_type     expected;
      logic              taken;
      logic              load;
      if (reset) begin
         req_valid    <= 1'b0;
         req_radicand <= '0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            expected.radicand = req_radicand;
            expected.root     = newton_root(req_radicand);
            awaited_roots.push_back(expected);
            issued_count <= issued_count + 1;
         end
         load = 1'b0;
         if ((!req_valid || taken) && pending_radicands.size() != 0) begin
            next_item = pending_radicands[0];
            load = ($urandom_range(0, 99) >= sender_idle_pct(next_item.phase));
            // pressure point: sender waits for every outstanding root
            if (next_item.drain_first && (taken || issued_count != returned_count))
               load = 1'b0;
         end
         if (load) begin
            void'(pending_radicands.pop_front());
            req_valid    <= 1'b1;
            req_radicand <= next_item.radicand;
            run_phase    <= next_item.phase;
         end else if (taken) begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random ready per phase, every accepted root checked in order.
   always @(posedge clock) begin
      root_item_type wanted;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct(run_phase));
         if (rsp_valid && rsp_ready) begin
            returned_count <= returned_count + 1;
            if (awaited_roots.size() == 0) begin
               $display("%0t: unexpected root: expected none, got %h", $time, rsp_root);
               error_count++;
            end else begin
               wanted = awaited_roots.pop_front();
               if (rsp_root !== wanted.root) begin
                  $display("%0t: root of %0d: expected %h, got %h",
                           $time, wanted.radicand, wanted.root, rsp_root);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel means a hang.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
      $display("FAIL newton_square_root");
      $finish;
   end

   initial begin
      logic [RADICAND_BITS-1:0] corner_values [DIRECTED_COUNT];
      flow_phase_type           phase;
      // corners: zero, tiny values, powers of two, perfect squares, all-ones,
      // the largest square that fits, and alternating bit patterns
      corner_values = '{
         31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd15, 31'd16, 31'd99,
         31'd100, 31'd65535, 31'd65536, 31'h4000_0000, 31'h3FFF_FFFF,
         31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'd2147395600, 31'd2147395601,
         31'h2AAA_AAAA, 31'h5555_5555, 31'd12345678
      };
      foreach (corner_values[i])
         queue_radicand(corner_values[i], PH_SLOW_RECEIVER, 1'b0);
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         phase = (i < 180) ? PH_SLOW_RECEIVER : (i < 370) ? PH_SLOW_SENDER : PH_FULL_RATE;
         // first item of each later phase waits until the block has fully drained
         queue_radicand(random_radicand(), phase, (i == 180) || (i == 370));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_radicands.size() != 0 || req_valid)
         @(posedge clock);
      while (returned_count != issued_count)
         @(posedge clock);
      // catch any stray extra result
      repeat (TAIL_CYCLES) @(posedge clock);

      if (awaited_roots.size() != 0) begin
         $display("%0t: %0d roots never arrived", $time, awaited_roots.size());
         error_count++;
      end
      $display("Checked %0d square roots (corners plus random magnitudes) under three",
               returned_count);
      $display("flow-control phases with drain pauses; %0d mismatches", error_count);
      if (error_count == 0)
         $display("PASS newton_square_root");
      else
         $display("FAIL newton_square_root");
      $finish;
   end

endmodule
